// ===== rtl/core/pbrle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits RLE encoder package
// Word types, run modes and token helpers shared by the encoder.
// ----------------------------------------------------------------------------
package pbrle_pkg;

  // Bytes per output word and the lane index width
  localparam int unsigned OUT_LANES = 4;
  localparam int unsigned LANE_W    = $clog2(OUT_LANES);

  // Pending byte store
  localparam int unsigned PEND_DEPTH = 128;
  localparam int unsigned PEND_AW    = $clog2(PEND_DEPTH);
  localparam logic [7:0]  LIT_MAX    = 8'd128;

  // Repeat header is 257 minus the run length
  localparam logic [8:0]  REP_BASE = 9'd257;

  // Run modes
  localparam logic [1:0] MODE_UND = 2'd0;
  localparam logic [1:0] MODE_REP = 2'd1;
  localparam logic [1:0] MODE_LIT = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic [2:0] byte_count;
    logic       last_of_burst;
  } out_item_t;

  // One closed token waiting for output
  typedef struct packed {
    logic       rep;
    logic [7:0] len;
    logic [7:0] val;
  } token_t;

  function automatic token_t mk_rep(input logic [7:0] len, input logic [7:0] val);
    token_t t;
    t.rep = 1'b1;
    t.len = len;
    t.val = val;
    return t;
  endfunction

  function automatic token_t mk_lit(input logic [7:0] len);
    token_t t;
    t.rep = 1'b0;
    t.len = len;
    t.val = 8'd0;
    return t;
  endfunction

  function automatic logic [7:0] hdr_byte(input token_t t);
    logic [8:0] r;
    r = REP_BASE - {1'b0, t.len};
    return t.rep ? r[7:0] : (t.len - 8'd1);
  endfunction

endpackage

// ===== rtl/core/packbits_rle_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits RLE encoder
// Encodes a byte stream into repeat and literal tokens, four bytes per word.
// ----------------------------------------------------------------------------
// An input word that closes no token does not stall the input. A word that
// closes tokens (a full run, a broken run, a full literal, or a flush) holds
// the input until the N encoded bytes that it yields (up to 129) have passed
// the byte stage: the encoded bytes are produced one per cycle while packing
// does not stall, literal bytes coming through the single read port of the
// 128-entry pending byte memory. The output side has its own packing and
// output registers, so finished words drain while the next input word is
// taken. The pending memory needs no clearing after reset. MAX_RUN (2 to 128) caps the length of a repeat token.
module packbits_rle_encoder
  import pbrle_pkg::*;
#(
  parameter int unsigned MAX_RUN = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam logic [7:0] MaxRunC = 8'(MAX_RUN);

  // Encoder state
  logic [1:0] mode_q, mode_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] first_q, first_d;
  logic [7:0] prev_q, prev_d;

  logic [7:0] mem_q [PEND_DEPTH];
  logic [7:0] rdata_q;

  // Token queue and byte sequencer
  token_t tok0_q, tok1_q;
  logic   tok0_vld_q, tok1_vld_q;
  logic   hdr_q;
  logic [PEND_AW-1:0] bidx_q;

  // Byte stage after the memory read
  logic       s1_vld_q, s1_mem_q, s1_last_q;
  logic [7:0] s1_const_q;

  // Packing word and output word
  logic [7:0] lane_q [OUT_LANES];
  logic [2:0] pack_cnt_q;
  logic       pack_last_q;
  logic       out_vld_q;
  out_item_t  out_q;

  logic in_acc;
  logic wr_en;
  logic [PEND_AW-1:0] wr_addr;
  token_t em [2];
  logic [1:0] ne;

  assign in_stall_o = tok0_vld_q | s1_vld_q;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // Next state and closed tokens for an accepted word
  always_comb begin
    logic [7:0] b;
    logic [7:0] c;
    b       = in_data_i.data_byte;
    c       = cnt_q + 8'd1;
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    first_d = first_q;
    prev_d  = prev_q;
    wr_en   = 1'b0;
    wr_addr = '0;
    em[0]   = '0;
    em[1]   = '0;
    ne      = 2'd0;

    if (in_data_i.has_byte) begin
      prev_d = b;
      case (mode_q)
        MODE_REP: begin
          if (b == first_q) begin
            cnt_d = c;
            if (c >= MaxRunC) begin
              em[ne[0]] = mk_rep(c, first_q);
              ne        = ne + 2'd1;
              cnt_d     = 8'd0;
              mode_d    = MODE_UND;
            end
          end else begin
            em[ne[0]] = mk_rep(cnt_q, first_q);
            ne        = ne + 2'd1;
            first_d   = b;
            cnt_d     = 8'd1;
            mode_d    = MODE_UND;
            wr_en     = 1'b1;
            wr_addr   = '0;
          end
        end
        MODE_LIT: begin
          if (b == prev_q) begin
            // Last literal byte moves over into the new run
            em[ne[0]] = mk_lit(cnt_q - 8'd1);
            ne        = ne + 2'd1;
            first_d   = b;
            cnt_d     = 8'd2;
            mode_d    = MODE_REP;
            if (8'd2 >= MaxRunC) begin
              em[ne[0]] = mk_rep(8'd2, b);
              ne        = ne + 2'd1;
              cnt_d     = 8'd0;
              mode_d    = MODE_UND;
            end
          end else begin
            wr_en   = 1'b1;
            wr_addr = cnt_q[PEND_AW-1:0];
            cnt_d   = c;
            if (c >= LIT_MAX) begin
              em[ne[0]] = mk_lit(c);
              ne        = ne + 2'd1;
              cnt_d     = 8'd0;
              mode_d    = MODE_UND;
            end
          end
        end
        default: begin
          wr_en = 1'b1;
          if (cnt_q == 8'd0) begin
            wr_addr = '0;
            first_d = b;
            cnt_d   = 8'd1;
          end else begin
            wr_addr = PEND_AW'(1);
            cnt_d   = 8'd2;
            if (b == first_q) begin
              mode_d = MODE_REP;
              if (8'd2 >= MaxRunC) begin
                em[ne[0]] = mk_rep(8'd2, first_q);
                ne        = ne + 2'd1;
                cnt_d     = 8'd0;
                mode_d    = MODE_UND;
              end
            end else begin
              mode_d = MODE_LIT;
            end
          end
        end
      endcase
    end

    if (in_data_i.end_of_stream && (cnt_d != 8'd0)) begin
      em[ne[0]] = (mode_d == MODE_REP) ? mk_rep(cnt_d, first_d) : mk_lit(cnt_d);
      ne        = ne + 2'd1;
      cnt_d     = 8'd0;
      mode_d    = MODE_UND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_UND;
      cnt_q   <= 8'd0;
      first_q <= 8'd0;
      prev_q  <= 8'd0;
    end else if (in_acc) begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
      prev_q  <= prev_d;
    end
  end

  // Byte sequencer: header, then the run byte or the literal bytes
  logic [7:0] s0_const;
  logic       s0_mem, s0_tok_end, s0_last, adv0;
  logic       pack_done, move, pack_take, pack_start;
  logic [7:0] s1_byte;

  assign s0_mem     = ~hdr_q & ~tok0_q.rep;
  assign s0_const   = hdr_q ? hdr_byte(tok0_q) : tok0_q.val;
  assign s0_tok_end = ~hdr_q & (tok0_q.rep | ({1'b0, bidx_q} == (tok0_q.len - 8'd1)));
  assign s0_last    = s0_tok_end & ~tok1_vld_q;
  assign adv0       = tok0_vld_q & (~s1_vld_q | pack_take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok0_vld_q <= 1'b0;
      tok1_vld_q <= 1'b0;
      tok0_q     <= '0;
      tok1_q     <= '0;
      hdr_q      <= 1'b1;
      bidx_q     <= '0;
    end else if (in_acc) begin
      tok0_vld_q <= (ne != 2'd0);
      tok1_vld_q <= (ne == 2'd2);
      tok0_q     <= em[0];
      tok1_q     <= em[1];
      hdr_q      <= 1'b1;
      bidx_q     <= '0;
    end else if (adv0) begin
      if (s0_tok_end) begin
        tok0_q     <= tok1_q;
        tok0_vld_q <= tok1_vld_q;
        tok1_vld_q <= 1'b0;
        hdr_q      <= 1'b1;
        bidx_q     <= '0;
      end else if (hdr_q) begin
        hdr_q <= 1'b0;
      end else begin
        bidx_q <= bidx_q + PEND_AW'(1);
      end
    end
  end

  // Pending byte memory
  always_ff @(posedge clk_i) begin
    if (in_acc && wr_en) begin
      mem_q[wr_addr] <= in_data_i.data_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv0 && s0_mem) begin
      rdata_q <= mem_q[bidx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s1_mem_q   <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_const_q <= 8'd0;
    end else if (adv0) begin
      s1_vld_q   <= 1'b1;
      s1_mem_q   <= s0_mem;
      s1_last_q  <= s0_last;
      s1_const_q <= s0_const;
    end else if (pack_take) begin
      s1_vld_q <= 1'b0;
    end
  end

  assign s1_byte = s1_mem_q ? rdata_q : s1_const_q;

  // Packing: fill lanes, hand a full or final word to the output register
  assign pack_done  = (pack_cnt_q != 3'd0) &
                      ((pack_cnt_q == 3'(OUT_LANES)) | pack_last_q);
  assign move       = pack_done & (~out_vld_q | ~out_stall_i);
  assign pack_take  = s1_vld_q & (~pack_done | move);
  assign pack_start = (pack_cnt_q == 3'd0) | pack_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_cnt_q  <= 3'd0;
      pack_last_q <= 1'b0;
      for (int i = 0; i < OUT_LANES; i++) begin
        lane_q[i] <= 8'd0;
      end
    end else if (pack_take) begin
      pack_last_q <= s1_last_q;
      if (pack_start) begin
        for (int i = 1; i < OUT_LANES; i++) begin
          lane_q[i] <= 8'd0;
        end
        lane_q[0]  <= s1_byte;
        pack_cnt_q <= 3'd1;
      end else begin
        lane_q[pack_cnt_q[LANE_W-1:0]] <= s1_byte;
        pack_cnt_q <= pack_cnt_q + 3'd1;
      end
    end else if (move) begin
      pack_cnt_q  <= 3'd0;
      pack_last_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else if (move) begin
      out_vld_q           <= 1'b1;
      out_q.out_byte0     <= lane_q[0];
      out_q.out_byte1     <= lane_q[1];
      out_q.out_byte2     <= lane_q[2];
      out_q.out_byte3     <= lane_q[3];
      out_q.byte_count    <= pack_cnt_q;
      out_q.last_of_burst <= pack_last_q;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Assertions
  a_tok_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok1_vld_q |-> tok0_vld_q)
    else $error("second token queued without a first");

  a_rep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_REP) |-> ((cnt_q >= 8'd2) && (cnt_q < MaxRunC)))
    else $error("open run length out of range");

  a_lit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_LIT) |-> ((cnt_q >= 8'd2) && (cnt_q < LIT_MAX)))
    else $error("open literal length out of range");

  a_pack_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pack_cnt_q <= 3'(OUT_LANES))
    else $error("packing word overfilled");

  a_empty_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_data_i.has_byte && (!in_data_i.end_of_stream || cnt_q == 8'd0))
      |=> !tok0_vld_q)
    else $error("token queued for a word that closes nothing");

endmodule
